// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/rclp_pkg.sv =====
package rclp_pkg;

  localparam int LINE_MAX_DEF = 32;

  localparam logic [7:0] CHAR_NUL  = 8'd0;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_SP   = 8'd32;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] SPD_LO    = 8'd49;
  localparam logic [7:0] SPD_HI    = 8'd52;
  localparam logic [7:0] CHAR_TWO  = 8'd50;

  localparam logic [9:0] AZ_MAX = 10'd360;
  localparam logic [9:0] EL_MAX = 10'd180;

  // Token length codes: saturated values mean "too long".
  localparam logic [2:0] FIRST_LONG  = 3'd5;
  localparam logic [2:0] SECOND_LONG = 3'd4;
  localparam logic [1:0] TOK_IDX_SAT = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE = 5'd0,
    CMD_O    = 5'd1,
    CMD_O2   = 5'd2,
    CMD_F    = 5'd3,
    CMD_F2   = 5'd4,
    CMD_R    = 5'd5,
    CMD_U    = 5'd6,
    CMD_L    = 5'd7,
    CMD_D    = 5'd8,
    CMD_A    = 5'd9,
    CMD_E    = 5'd10,
    CMD_S    = 5'd11,
    CMD_C    = 5'd12,
    CMD_B    = 5'd13,
    CMD_C2   = 5'd14,
    CMD_X    = 5'd15,
    CMD_M    = 5'd16,
    CMD_W    = 5'd17
  } cmd_t;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_INVALID   = 4'd1,
    ERR_SPEED     = 4'd2,
    ERR_M_HUND    = 4'd3,
    ERR_M_TENS    = 4'd4,
    ERR_M_UNITS   = 4'd5,
    ERR_M_RANGE   = 4'd6,
    ERR_W_HUND    = 4'd7,
    ERR_W_TENS    = 4'd8,
    ERR_W_UNITS   = 4'd9,
    ERR_EL_LEN    = 4'd10,
    ERR_EL_HUND   = 4'd11,
    ERR_EL_TENS   = 4'd12,
    ERR_EL_UNITS  = 4'd13,
    ERR_AZ_RANGE  = 4'd14,
    ERR_EL_RANGE  = 4'd15
  } err_t;

  // Tokens collected for one line.
  typedef struct packed {
    logic [3:0][7:0] first_tok;
    logic [2:0]      first_len;
    logic [2:0][7:0] second_tok;
    logic [2:0]      second_len;
    logic [1:0]      tok_idx;
  } line_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Three ASCII digits to a value; low nibble of a digit is its value.
  function automatic logic [9:0] three_digits(input logic [7:0] h, input logic [7:0] t,
                                              input logic [7:0] u);
    return 10'(10'(h[3:0]) * 10'd100) + 10'(10'(t[3:0]) * 10'd10) + 10'(u[3:0]);
  endfunction

endpackage

// ===== design/rclp_tokenizer.sv =====
module rclp_tokenizer #(
  parameter int LINE_MAX = rclp_pkg::LINE_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     rx_byte,
  output logic           rec_valid,
  output rclp_pkg::line_t rec,
  input  logic           rec_take
);
  import rclp_pkg::*;

  localparam int CNT_W = $clog2(LINE_MAX);

  line_t            line;
  line_t            line_next;
  logic             in_tok;
  logic             in_tok_next;
  logic             cut;
  logic             cut_next;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             end_char;
  logic             line_end;

  assign in_stall = rec_valid && !rec_take;
  assign accept   = in_valid && !in_stall;
  assign end_char = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
  assign line_end = end_char || (count == CNT_W'(LINE_MAX - 2));

  always_comb begin
    line_next   = line;
    in_tok_next = in_tok;
    cut_next    = cut;
    if (!cut) begin
      if (rx_byte == CHAR_NUL) begin
        cut_next = 1'b1;
      end else if (rx_byte == CHAR_SP) begin
        in_tok_next = 1'b0;
      end else begin
        if (!in_tok) begin
          in_tok_next = 1'b1;
          if (line.tok_idx != TOK_IDX_SAT) begin
            line_next.tok_idx = line.tok_idx + 2'd1;
          end
        end
        if (line_next.tok_idx == 2'd1) begin
          if (line.first_len < 3'd4) begin
            line_next.first_tok[line.first_len[1:0]] = rx_byte;
            line_next.first_len = line.first_len + 3'd1;
          end else begin
            line_next.first_len = FIRST_LONG;
          end
        end else if (line_next.tok_idx == 2'd2) begin
          if (line.second_len < 3'd3) begin
            line_next.second_tok[line.second_len[1:0]] = rx_byte;
            line_next.second_len = line.second_len + 3'd1;
          end else begin
            line_next.second_len = SECOND_LONG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      in_tok    <= 1'b0;
      cut       <= 1'b0;
      count     <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (rec_take) begin
        rec_valid <= 1'b0;
      end
      if (accept) begin
        if (line_end) begin
          rec       <= end_char ? line : line_next;
          rec_valid <= 1'b1;
          line      <= '0;
          in_tok    <= 1'b0;
          cut       <= 1'b0;
          count     <= '0;
        end else begin
          line   <= line_next;
          in_tok <= in_tok_next;
          cut    <= cut_next;
          count  <= count + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== design/rclp_decoder.sv =====
module rclp_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  input  rclp_pkg::line_t rec,
  output logic            rec_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      command,
  output logic [3:0]      error_code,
  output logic [8:0]      azimuth_target,
  output logic [7:0]      elevation_target,
  output logic [2:0]      speed
);
  import rclp_pkg::*;

  cmd_t       cmd;
  err_t       err;
  logic [2:0] spd;
  logic [9:0] az_val;
  logic [9:0] el_val;
  logic [7:0] c0, c1, c2, c3;
  logic [8:0] az_target;
  logic [7:0] el_target;
  logic [8:0] az_target_next;
  logic [7:0] el_target_next;

  assign rec_take = rec_valid && (!out_valid || !out_stall);

  assign c0 = rec.first_tok[0];
  assign c1 = rec.first_tok[1];
  assign c2 = rec.first_tok[2];
  assign c3 = rec.first_tok[3];
  assign az_val = three_digits(c1, c2, c3);
  assign el_val = three_digits(rec.second_tok[0], rec.second_tok[1], rec.second_tok[2]);

  always_comb begin
    cmd            = CMD_NONE;
    err            = ERR_OK;
    spd            = 3'd0;
    az_target_next = az_target;
    el_target_next = el_target;
    if (rec.tok_idx == 2'd0 || rec.first_len inside {3'd0, 3'd3} || rec.first_len > 3'd4) begin
      err = ERR_INVALID;
    end else if (rec.first_len == 3'd1) begin
      case (c0)
        "O":     cmd = CMD_O;
        "F":     cmd = CMD_F;
        "R":     cmd = CMD_R;
        "U":     cmd = CMD_U;
        "L":     cmd = CMD_L;
        "D":     cmd = CMD_D;
        "A":     cmd = CMD_A;
        "E":     cmd = CMD_E;
        "S":     cmd = CMD_S;
        "C":     cmd = CMD_C;
        "B":     cmd = CMD_B;
        default: err = ERR_INVALID;
      endcase
    end else if (rec.first_len == 3'd2) begin
      if (c1 == CHAR_TWO && c0 == "O") begin
        cmd = CMD_O2;
      end else if (c1 == CHAR_TWO && c0 == "F") begin
        cmd = CMD_F2;
      end else if (c1 == CHAR_TWO && c0 == "C") begin
        cmd = CMD_C2;
      end else if (c0 == "X") begin
        if (c1 inside {[SPD_LO:SPD_HI]}) begin
          spd = c1[2:0];
          cmd = CMD_X;
        end else begin
          err = ERR_SPEED;
        end
      end else begin
        err = ERR_INVALID;
      end
    end else if (c0 == "M") begin
      if (!is_digit(c1)) begin
        err = ERR_M_HUND;
      end else if (!is_digit(c2)) begin
        err = ERR_M_TENS;
      end else if (!is_digit(c3)) begin
        err = ERR_M_UNITS;
      end else if (az_val > AZ_MAX) begin
        err = ERR_M_RANGE;
      end else begin
        az_target_next = az_val[8:0];
        cmd            = CMD_M;
      end
    end else if (c0 == "W") begin
      if (!is_digit(c1)) begin
        err = ERR_W_HUND;
      end else if (!is_digit(c2)) begin
        err = ERR_W_TENS;
      end else if (!is_digit(c3)) begin
        err = ERR_W_UNITS;
      end else if (rec.tok_idx < 2'd2 || rec.second_len != 3'd3) begin
        err = ERR_EL_LEN;
      end else if (!is_digit(rec.second_tok[0])) begin
        err = ERR_EL_HUND;
      end else if (!is_digit(rec.second_tok[1])) begin
        err = ERR_EL_TENS;
      end else if (!is_digit(rec.second_tok[2])) begin
        err = ERR_EL_UNITS;
      end else if (az_val > AZ_MAX) begin
        err = ERR_AZ_RANGE;
      end else if (el_val > EL_MAX) begin
        err = ERR_EL_RANGE;
      end else begin
        az_target_next = az_val[8:0];
        el_target_next = el_val[7:0];
        cmd            = CMD_W;
      end
    end else begin
      err = ERR_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      az_target <= '0;
      el_target <= '0;
    end else if (rec_take) begin
      out_valid        <= 1'b1;
      az_target        <= az_target_next;
      el_target        <= el_target_next;
      command          <= cmd;
      error_code       <= err;
      speed            <= spd;
      azimuth_target   <= az_target_next;
      elevation_target <= el_target_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/rotator_command_line_parser_core.sv =====
// A line-ending byte is caught in the record register, then decoded into the result register.
// Throughput: one byte per cycle while in_stall is low; the line buffer stage and the result register
// pass beats every cycle while the output is not stalled.
// Reset (rst, synchronous, active high): clears the line in progress, both stored
// targets and both valid flags; no clearing pass is needed.
module rotator_command_line_parser_core #(
  parameter int LINE_MAX = rclp_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] command,
  output logic [3:0] error_code,
  output logic [8:0] azimuth_target,
  output logic [7:0] elevation_target,
  output logic [2:0] speed
);
  import rclp_pkg::*;

  // Finished line, handed from the tokenizer to the decoder. The tokenizer
  // stalls its input while this record waits untaken.
  line_t rec;
  logic  rec_valid;
  logic  rec_take;

  // Stage 1: split bytes into tokens; hold the tokens of a finished line
  // (CR, LF, or a full line) in a one-entry record register. Stall input
  // only when that record is full and the decoder cannot take it.
  rclp_tokenizer #(
    .LINE_MAX (LINE_MAX)
  ) u_tokenizer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take)
  );

  // Stage 2: decode the record, update the stored targets on a valid M or W
  // line, and load the result register. Advance whenever the result register
  // is empty or its beat is taken this cycle.
  rclp_decoder u_decoder (
    .clk              (clk),
    .rst              (rst),
    .rec_valid        (rec_valid),
    .rec              (rec),
    .rec_take         (rec_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .command          (command),
    .error_code       (error_code),
    .azimuth_target   (azimuth_target),
    .elevation_target (elevation_target),
    .speed            (speed)
  );

endmodule

// ===== design/rclp_checker.sv =====
`include "assert_macros.svh"

module rclp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] command,
  input logic [3:0] error_code,
  input logic [8:0] azimuth_target,
  input logic [7:0] elevation_target,
  input logic [2:0] speed
);
  import rclp_pkg::*;

  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result beat right after reset")

  `CHK_ASSERT(a_err_no_cmd, clk, rst, (out_valid && error_code != ERR_OK) |-> (command == CMD_NONE), "command given with an error")

  `CHK_ASSERT(a_speed_only_x, clk, rst, (out_valid && command != CMD_X) |-> (speed == 3'd0), "speed set on a line that is not X")

  `CHK_ASSERT(a_target_range, clk, rst, out_valid |-> (azimuth_target <= 9'd360 && elevation_target <= 8'd180), "stored target out of range")

  `CHK_ASSERT(a_hold_stalled, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(command) && $stable(error_code) && $stable(azimuth_target)), "stalled result beat changed")

endmodule

bind rotator_command_line_parser_core rclp_checker u_rclp_checker (.*);

// ===== bench/tb_rotator_command_line_parser_core.sv =====
module tb_rotator_command_line_parser_core;
  import rclp_pkg::*;

  // Bound the run well above the slowest legal pace: ~1100 bytes, each with
  // sender gaps and a receiver that stalls 80 percent of the time.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_BYTES = 1050;
  localparam int DRAIN_CYCLES = 8;

  // One decoded line as the block reports it.
  typedef struct packed {
    cmd_t       cmd;
    err_t       err;
    logic [8:0] az;
    logic [7:0] el;
    logic [2:0] spd;
  } line_verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] command;
  logic [3:0] error_code;
  logic [8:0] azimuth_target;
  logic [7:0] elevation_target;
  logic [2:0] speed;

  rotator_command_line_parser_core #(.LINE_MAX(LINE_MAX_DEF)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .command          (command),
    .error_code       (error_code),
    .azimuth_target   (azimuth_target),
    .elevation_target (elevation_target),
    .speed            (speed)
  );

  always #10 clk = ~clk;

  // Bytes waiting to be sent and verdicts waiting to come back.
  logic [7:0]    pending_bytes[$];
  line_verdict_t expected_verdicts[$];

  int total_bytes    = 0;
  int bytes_issued   = 0;
  int bytes_accepted = 0;
  int lines_checked  = 0;
  int lines_ok       = 0;
  int target_moves   = 0;
  int fail_count     = 0;
  int cycles         = 0;
  int sender_idle_pct   = 33;
  int receiver_idle_pct = 80;

  string fixed_cmds[14] = '{"O", "O2", "F", "F2", "R", "U", "L", "D", "A", "E", "S", "C",
                            "B", "C2"};

  // ---------------------------------------------------------------------------
  // Line decoder mirror: its own copy of the line in progress and the targets.
  // ---------------------------------------------------------------------------
  int unsigned     line_len    = 0;
  logic [3:0][7:0] word1       = '0;
  logic [2:0]      word1_len   = '0;
  logic [2:0][7:0] word2       = '0;
  logic [2:0]      word2_len   = '0;
  logic [1:0]      words_begun = '0;
  bit              in_word     = 1'b0;
  bit              text_ended  = 1'b0;
  logic [8:0]      az_set      = '0;
  logic [7:0]      el_set      = '0;

  function automatic void start_new_line();
    line_len    = 0;
    word1       = '0;
    word1_len   = '0;
    word2       = '0;
    word2_len   = '0;
    words_begun = '0;
    in_word     = 1'b0;
    text_ended  = 1'b0;
  endfunction

  function automatic bit is_ascii_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic int degrees_of(input logic [7:0] h, input logic [7:0] t,
                                    input logic [7:0] u);
    return (int'(h) - 48) * 100 + (int'(t) - 48) * 10 + (int'(u) - 48);
  endfunction

  // Fold one text byte into the token store. A zero byte ends the text; later
  // bytes still count toward the line length but are not stored.
  function automatic void absorb_char(input logic [7:0] c);
    if (text_ended) return;
    if (c == CHAR_NUL) begin
      text_ended = 1'b1;
      return;
    end
    if (c == CHAR_SP) begin
      in_word = 1'b0;
      return;
    end
    if (!in_word) begin
      in_word = 1'b1;
      if (words_begun != TOK_IDX_SAT) words_begun++;
    end
    if (words_begun == 2'd1) begin
      if (word1_len < 3'd4) begin
        word1[word1_len[1:0]] = c;
        word1_len++;
      end else begin
        word1_len = FIRST_LONG;
      end
    end else if (words_begun == 2'd2) begin
      if (word2_len < 3'd3) begin
        word2[word2_len[1:0]] = c;
        word2_len++;
      end else begin
        word2_len = SECOND_LONG;
      end
    end
  endfunction

  // Decode the collected tokens; valid M and W lines move the stored targets.
  function automatic line_verdict_t decode_line();
    line_verdict_t v;
    logic [7:0] c0, c1, c2, c3;
    int az, el;
    v.cmd = CMD_NONE;
    v.err = ERR_OK;
    v.spd = 3'd0;
    c0 = word1[0];
    c1 = word1[1];
    c2 = word1[2];
    c3 = word1[3];
    az = degrees_of(c1, c2, c3);
    el = degrees_of(word2[0], word2[1], word2[2]);
    if (words_begun == 2'd0 || word1_len == 3'd0 || word1_len == 3'd3 || word1_len > 3'd4) begin
      v.err = ERR_INVALID;
    end else if (word1_len == 3'd1) begin
      case (c0)
        "O": v.cmd = CMD_O;
        "F": v.cmd = CMD_F;
        "R": v.cmd = CMD_R;
        "U": v.cmd = CMD_U;
        "L": v.cmd = CMD_L;
        "D": v.cmd = CMD_D;
        "A": v.cmd = CMD_A;
        "E": v.cmd = CMD_E;
        "S": v.cmd = CMD_S;
        "C": v.cmd = CMD_C;
        "B": v.cmd = CMD_B;
        default: v.err = ERR_INVALID;
      endcase
    end else if (word1_len == 3'd2) begin
      if (c1 == CHAR_TWO && c0 == "O") v.cmd = CMD_O2;
      else if (c1 == CHAR_TWO && c0 == "F") v.cmd = CMD_F2;
      else if (c1 == CHAR_TWO && c0 == "C") v.cmd = CMD_C2;
      else if (c0 == "X") begin
        if (c1 < SPD_LO || c1 > SPD_HI) v.err = ERR_SPEED;
        else begin
          v.spd = 3'(c1 - CHAR_ZERO);
          v.cmd = CMD_X;
        end
      end else v.err = ERR_INVALID;
    end else if (c0 == "M") begin
      if (!is_ascii_digit(c1)) v.err = ERR_M_HUND;
      else if (!is_ascii_digit(c2)) v.err = ERR_M_TENS;
      else if (!is_ascii_digit(c3)) v.err = ERR_M_UNITS;
      else if (az > 360) v.err = ERR_M_RANGE;
      else begin
        az_set = 9'(az);
        v.cmd  = CMD_M;
      end
    end else if (c0 == "W") begin
      if (!is_ascii_digit(c1)) v.err = ERR_W_HUND;
      else if (!is_ascii_digit(c2)) v.err = ERR_W_TENS;
      else if (!is_ascii_digit(c3)) v.err = ERR_W_UNITS;
      else if (words_begun < 2'd2 || word2_len != 3'd3) v.err = ERR_EL_LEN;
      else if (!is_ascii_digit(word2[0])) v.err = ERR_EL_HUND;
      else if (!is_ascii_digit(word2[1])) v.err = ERR_EL_TENS;
      else if (!is_ascii_digit(word2[2])) v.err = ERR_EL_UNITS;
      else if (az > 360) v.err = ERR_AZ_RANGE;
      else if (el > 180) v.err = ERR_EL_RANGE;
      else begin
        az_set = 9'(az);
        el_set = 8'(el);
        v.cmd  = CMD_W;
      end
    end else begin
      v.err = ERR_INVALID;
    end
    v.az = az_set;
    v.el = el_set;
    return v;
  endfunction

  // Advance the mirror by one accepted byte; returns 1 when a line closes.
  // A line closes on CR or LF, or on the byte that fills the line store.
  function automatic bit feed_byte(input logic [7:0] b, output line_verdict_t v);
    if (b == CHAR_LF || b == CHAR_CR) begin
      v = decode_line();
      start_new_line();
      return 1'b1;
    end
    absorb_char(b);
    line_len++;
    if (line_len >= LINE_MAX_DEF - 1) begin
      v = decode_line();
      start_new_line();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic put_line(input string s);
    put_text(s);
    pending_bytes.push_back(CHAR_CR);
  endtask

  // Three-digit field, now and then with one character spoiled.
  function automatic string three_chars(input int value, input int bad_pct);
    string s;
    s = $sformatf("%03d", value);
    if ($urandom_range(0, 99) < bad_pct) begin
      if ($urandom_range(0, 1) != 0) s[$urandom_range(0, 2)] = 8'($urandom_range(58, 126));
      else s[$urandom_range(0, 2)] = 8'($urandom_range(33, 47));
    end
    return s;
  endfunction

  task automatic put_random_line();
    int kind;
    int el_len;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) pending_bytes.push_back(CHAR_SP);
    if (kind < 15) begin
      put_text(fixed_cmds[$urandom_range(0, 13)]);
    end else if (kind < 25) begin
      pending_bytes.push_back("X");
      pending_bytes.push_back(8'($urandom_range(47, 54)));
    end else if (kind < 50) begin
      pending_bytes.push_back("M");
      put_text(three_chars($urandom_range(0, 399), 12));
    end else if (kind < 85) begin
      pending_bytes.push_back("W");
      put_text(three_chars($urandom_range(0, 399), 8));
      el_len = $urandom_range(0, 9);
      if (el_len != 0) begin
        repeat ($urandom_range(1, 2)) pending_bytes.push_back(CHAR_SP);
        if (el_len < 8) put_text(three_chars($urandom_range(0, 199), 10));
        else put_text($sformatf("%0d", $urandom_range(0, 9999)));
        // Tokens past the second should be ignored.
        if ($urandom_range(0, 9) == 0) put_text(" 77 x");
      end
    end else if (kind < 95) begin
      // Raw noise over the whole byte range; may close lines by itself.
      repeat ($urandom_range(0, 8)) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Long line that may reach the store limit before any terminator.
      repeat ($urandom_range(28, 40)) begin
        if ($urandom_range(0, 4) == 0) pending_bytes.push_back(CHAR_SP);
        else pending_bytes.push_back(8'($urandom_range(33, 126)));
      end
    end
    // Occasionally cut the text with a zero byte and trail some garbage.
    if ($urandom_range(0, 19) == 0) begin
      pending_bytes.push_back(CHAR_NUL);
      put_text("W1");
    end
    case ($urandom_range(0, 2))
      0: pending_bytes.push_back(CHAR_CR);
      1: pending_bytes.push_back(CHAR_LF);
      default: begin
        pending_bytes.push_back(CHAR_CR);
        pending_bytes.push_back(CHAR_LF);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next byte, hold it while stalled, predict on accept.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    line_verdict_t v;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        if (feed_byte(rx_byte, v)) expected_verdicts.push_back(v);
        bytes_accepted++;
      end
      // Idle pattern by progress: sender light / receiver heavy, then swapped,
      // then flat out.
      if (bytes_issued < total_bytes / 3) begin
        sender_idle_pct   = 33;
        receiver_idle_pct = 80;
      end else if (bytes_issued < (2 * total_bytes) / 3) begin
        sender_idle_pct   = 80;
        receiver_idle_pct = 33;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      // Hold a stalled beat; otherwise advance or drop valid.
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
          bytes_issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each result beat with the oldest verdict.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    line_verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no line pending: command %0d error_code %0d",
                 command, error_code);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("command", int'(want.cmd), int'(command));
          compare_field("error_code", int'(want.err), int'(error_code));
          compare_field("azimuth_target", int'(want.az), int'(azimuth_target));
          compare_field("elevation_target", int'(want.el), int'(elevation_target));
          compare_field("speed", int'(want.spd), int'(speed));
          lines_checked++;
          if (want.err == ERR_OK) lines_ok++;
          if (want.cmd == CMD_M || want.cmd == CMD_W) target_moves++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_rotator_command_line_parser_core: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed lines, random lines, reset, then wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    // Every fixed command, speed digits at and past both ends.
    foreach (fixed_cmds[i]) put_line(fixed_cmds[i]);
    put_line("X1");
    put_line("X4");
    put_line("X0");
    put_line("X5");
    // Azimuth move: limits, just over range, each digit position spoiled.
    put_line("M000");
    put_line("M360");
    put_line("M361");
    put_line("MA00");
    put_line("M0A0");
    put_line("M00A");
    // Azimuth and elevation move: both limits, ranges, each failing check.
    put_line("W360 180");
    put_line("W000 000");
    put_line("W361 000");
    put_line("W000 181");
    put_line("W/00 000");
    put_line("W0:0 000");
    put_line("W00a 000");
    put_line("W123");
    put_line("W123 45");
    put_line("W123 4567");
    put_line("W123 a00");
    put_line("W123 0b0");
    put_line("W123 00c");
    put_line("W010 020 030 040");
    // Blank and invalid first tokens, first token too long.
    put_line("");
    put_line("   ");
    put_line("Q");
    put_line("OO");
    put_line("MOVE");
    put_line("M1234");
    put_line("W12");
    // CR LF pair gives a second, empty line.
    put_text("S");
    pending_bytes.push_back(CHAR_CR);
    pending_bytes.push_back(CHAR_LF);
    // Zero byte cuts the text: only "O" counts.
    put_text("O");
    pending_bytes.push_back(CHAR_NUL);
    put_text("2 W1");
    pending_bytes.push_back(CHAR_LF);
    // Full line: a valid move padded to the store limit, no terminator.
    put_text("W100 050");
    repeat (LINE_MAX_DEF - 1 - 8) pending_bytes.push_back(CHAR_SP);
    // High-bit bytes.
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(CHAR_CR);

    total_bytes = TARGET_BYTES;
    while (pending_bytes.size() < total_bytes) put_random_line();
    total_bytes = pending_bytes.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is in and every line verdict has come back.
    while (bytes_accepted != total_bytes || expected_verdicts.size() != 0) @(posedge clk);
    // Give any stray result beat time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_verdicts.size() != 0) begin
      $error("%0d line results never arrived", expected_verdicts.size());
      fail_count++;
    end
    $display("sent %0d bytes, checked %0d line results (%0d accepted commands, %0d target moves)",
             bytes_accepted, lines_checked, lines_ok, target_moves);
    if (fail_count == 0) begin
      $display("tb_rotator_command_line_parser_core: clean");
    end else begin
      $display("tb_rotator_command_line_parser_core: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rclp_pkg.sv
design/rclp_tokenizer.sv
design/rclp_decoder.sv
design/rotator_command_line_parser_core.sv
design/rclp_checker.sv
bench/tb_rotator_command_line_parser_core.sv
